// File: rtl/core/rsif_pkg.sv
// Package for the RS485 idle-timeout framer: buffer sizing, event codes
// and the item types of the request and response channels.
// No dependencies; compile first.
package rsif_pkg;

   // buffer geometry
   localparam int BUF_DEPTH = 128;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);

   // idle countdown reload value after reset
   localparam logic [7:0] IDLE_RESET = 8'd5;

   // buffer depth at the width of the count and length fields
   localparam logic [7:0] DEPTH_CNT = 8'(BUF_DEPTH);

   // event codes
   localparam logic [2:0] OP_RX_BYTE = 3'd0;
   localparam logic [2:0] OP_TX_DONE = 3'd1;
   localparam logic [2:0] OP_TICK    = 3'd2;
   localparam logic [2:0] OP_LOAD_TX = 3'd3;
   localparam logic [2:0] OP_START   = 3'd4;
   localparam logic [2:0] OP_READ_RX = 3'd5;
   localparam logic [2:0] OP_RELEASE = 3'd6;

   // one request item
   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data;
      logic [6:0] index;
      logic [7:0] length;
   } req_type;

   // one response item
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       drive_enable;
      logic       frame_ready;
      logic [7:0] rx_length;
      logic [7:0] read_byte;
   } rsp_type;

endpackage

// File: rtl/core/rsif_channels.sv
// Valid/ready channel interfaces for the framer's request and response items.
// Depends on rsif_pkg for the item types.
interface rsif_req_if import rsif_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rsif_rsp_if import rsif_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/rs485_idle_timeout_framer_core.sv
// Top level of the RS485 idle-timeout framer.
// Depends on rsif_pkg, rsif_channels (interfaces) and rsif_ram.
//
// Usage:
//   req_if carries one event per item: received byte, transmit done, tick,
//   transmit buffer load, start of send, receive buffer read, release.
//   rsp_if returns exactly one item per event: the byte handed to the
//   transmitter (if any), driver enable, frame ready, bytes held and the
//   byte read back (read events only).
//   csr_write_enable/csr_write_data set the idle timeout in ticks; write
//   only while no events are in flight.
// Timing:
//   One event per cycle sustained while rsp_if.ready stays high. An event
//   passes the registered buffer read and the stage 1 register, then the
//   output register. Counters update in the accept cycle, so consecutive
//   events see each other's effect at once; each buffer sees at most one
//   access per event and a write is visible to a read in the following
//   cycle, so no forwarding path is needed.
// Reset: synchronous; clears counters, flags and the pipeline, sets the
//   idle timeout to five ticks. Buffer contents stay undefined until written.
// Stall: when rsp_if.ready is low the output holds, the middle stage fills,
//   and req_if.ready drops until the response is taken.
module rs485_idle_timeout_framer_core import rsif_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rsif_req_if.sink    req_if,
   rsif_rsp_if.source  rsp_if,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   // scalar state
   logic [7:0]        idle_timeout_ff;
   logic [7:0]        rx_count_ff, rx_count_in;
   logic [7:0]        idle_left_ff, idle_left_in;
   logic              frame_done_ff, frame_done_in;
   logic [ADDR_W-1:0] tx_pos_ff, tx_pos_in;
   logic [7:0]        tx_left_ff, tx_left_in;
   logic              driving_ff, driving_in;

   // pipeline
   logic    s1_valid_ff;
   rsp_type s1_meta_ff, s1_meta_in;
   logic    s2_valid_ff;
   rsp_type s2_ff, s2_in;
   logic    s1_adv;
   logic    accept;

   // buffer ports
   logic              rx_wr_en, tx_wr_en, rx_rd_en, tx_rd_en;
   logic [ADDR_W-1:0] rx_wr_addr, tx_rd_addr;
   logic [7:0]        rx_rd_data, tx_rd_data;
   logic              tx_send;
   logic [7:0]        start_len;

   // handshake
   assign s1_adv       = s1_valid_ff && (!s2_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_if.valid && req_if.ready;

   // event decode and state update
   always_comb begin
      rx_count_in   = rx_count_ff;
      idle_left_in  = idle_left_ff;
      frame_done_in = frame_done_ff;
      tx_pos_in     = tx_pos_ff;
      tx_left_in    = tx_left_ff;
      driving_in    = driving_ff;
      rx_wr_en      = 1'b0;
      rx_wr_addr    = rx_count_ff[ADDR_W-1:0];
      tx_wr_en      = 1'b0;
      rx_rd_en      = 1'b0;
      tx_rd_en      = 1'b0;
      tx_rd_addr    = tx_pos_ff;
      tx_send       = 1'b0;
      start_len     = (req_if.payload.length > DEPTH_CNT) ? DEPTH_CNT
                                                          : req_if.payload.length;
      case (req_if.payload.op)
         OP_RX_BYTE: begin
            if (!frame_done_ff) begin
               rx_wr_en = accept;
               if (rx_count_ff >= DEPTH_CNT) begin
                  // full store wraps to the first entry
                  rx_wr_addr  = '0;
                  rx_count_in = 8'd1;
               end else begin
                  rx_count_in = rx_count_ff + 8'd1;
               end
            end
            idle_left_in = idle_timeout_ff;
         end
         OP_TX_DONE: begin
            if (tx_left_ff != 8'd0) begin
               tx_send    = 1'b1;
               tx_rd_en   = accept;
               tx_pos_in  = tx_pos_ff + 1'b1;
               tx_left_in = tx_left_ff - 8'd1;
            end else begin
               tx_pos_in  = '0;
               driving_in = 1'b0;
            end
         end
         OP_TICK: begin
            if (idle_left_ff != 8'd0) begin
               idle_left_in = idle_left_ff - 8'd1;
               if (idle_left_ff == 8'd1 && rx_count_ff != 8'd0) begin
                  frame_done_in = 1'b1;
               end
            end
         end
         OP_LOAD_TX: begin
            tx_wr_en = accept;
         end
         OP_START: begin
            if (!driving_ff) begin
               // first byte goes out with the start itself
               tx_rd_addr = '0;
               if (start_len != 8'd0) begin
                  tx_send    = 1'b1;
                  tx_rd_en   = accept;
                  tx_pos_in  = ADDR_W'(1);
                  tx_left_in = start_len - 8'd1;
                  driving_in = 1'b1;
               end else begin
                  tx_pos_in  = '0;
                  tx_left_in = 8'd0;
                  driving_in = 1'b0;
               end
            end
         end
         OP_READ_RX: begin
            rx_rd_en = accept;
         end
         OP_RELEASE: begin
            frame_done_in = 1'b0;
            rx_count_in   = 8'd0;
            idle_left_in  = 8'd0;
         end
         default: begin
         end
      endcase
   end

   // response fields known in the accept cycle; buffer bytes join later
   always_comb begin
      s1_meta_in              = '0;
      s1_meta_in.tx_valid     = tx_send;
      s1_meta_in.drive_enable = driving_in;
      s1_meta_in.frame_ready  = frame_done_in;
      s1_meta_in.rx_length    = rx_count_in;
      s1_meta_in.read_byte    = {7'd0, req_if.payload.op == OP_READ_RX};
   end

   // scalar registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= IDLE_RESET;
         rx_count_ff     <= 8'd0;
         idle_left_ff    <= 8'd0;
         frame_done_ff   <= 1'b0;
         tx_pos_ff       <= '0;
         tx_left_ff      <= 8'd0;
         driving_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            idle_timeout_ff <= csr_write_data;
         end
         if (accept) begin
            rx_count_ff   <= rx_count_in;
            idle_left_ff  <= idle_left_in;
            frame_done_ff <= frame_done_in;
            tx_pos_ff     <= tx_pos_in;
            tx_left_ff    <= tx_left_in;
            driving_ff    <= driving_in;
         end
      end
   end

   // receive and transmit buffers
   rsif_ram #(.DEPTH(BUF_DEPTH), .WIDTH(8)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (req_if.payload.data),
      .rd_en   (rx_rd_en),
      .rd_addr (req_if.payload.index[ADDR_W-1:0]),
      .rd_data (rx_rd_data)
   );

   rsif_ram #(.DEPTH(BUF_DEPTH), .WIDTH(8)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (req_if.payload.index[ADDR_W-1:0]),
      .wr_data (req_if.payload.data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // stage 1: waits for the buffer read; read data holds until the next accept
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
   end

   // stage 2: merge the buffer bytes into the item
   always_comb begin
      s2_in           = s1_meta_ff;
      s2_in.tx_byte   = s1_meta_ff.tx_valid ? tx_rd_data : 8'd0;
      s2_in.read_byte = s1_meta_ff.read_byte[0] ? rx_rd_data : 8'd0;
   end

   // stage 2: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_ff <= s2_in;
      end
   end

   assign rsp_if.valid   = s2_valid_ff;
   assign rsp_if.payload = s2_ff;

endmodule

// File: rtl/core/rsif_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read and a read enable. No dependencies; contents undefined at reset.
module rsif_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/rsif_checker.sv
// Port-level checks for the RS485 framer, bound to the top level.
// Depends on rsif_pkg and rs485_idle_timeout_framer_core.
module rsif_checker import rsif_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response item changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a byte is only handed out while the driver is enabled
   a_tx_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.tx_valid |-> rsp_payload.drive_enable)
      else $error("byte sent with driver disabled");

   // no transmit byte without its valid flag, count within the store
   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.tx_valid || rsp_payload.tx_byte == 8'd0)
                    && rsp_payload.rx_length <= DEPTH_CNT)
      else $error("stray transmit byte or receive count out of range");

endmodule

bind rs485_idle_timeout_framer_core rsif_checker u_rsif_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
